// ===== design/dct_idct_8x8_2d_unit_macros.svh =====
// Assertion macros shared by the transform block.
// No dependencies.
`ifndef DCT_IDCT_8X8_2D_UNIT_MACROS_SVH
`define DCT_IDCT_8X8_2D_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define DCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dct assertion failed");
// next-cycle implication
`define DCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dct assertion failed");
`endif

// ===== design/dct_pkg.sv =====
// Shared types, constants and arithmetic helpers of the 8x8 transform.
// No dependencies.
package dct_pkg;
  localparam int unsigned CoefBits = 16;
  localparam int unsigned PosBits  = 6;
  localparam int unsigned NumItems = 64;
  localparam int unsigned NumConst = 7;

  typedef enum logic [1:0] {
    OP_FWD_ROW = 2'd0,
    OP_FWD_COL = 2'd1,
    OP_INV_COL = 2'd2,
    OP_INV_ROW = 2'd3
  } op_e;

  // butterfly constants, 30 fraction bits
  function automatic logic [31:0] k_q30(input logic [2:0] idx);
    logic [31:0] r;
    begin
      case (idx)
        3'd0:    r = 32'd547388835;
        3'd1:    r = 32'd645689156;
        3'd2:    r = 32'd966342111;
        3'd3:    r = 32'd2751909508;
        3'd4:    r = 32'd581104888;
        3'd5:    r = 32'd1402911301;
        default: r = 32'd759250125;
      endcase
      return r;
    end
  endfunction
endpackage

// ===== design/dct_stream_if.sv =====
// Valid/ready stream interface carrying one payload.
// Depends on nothing; payload width is a parameter.
interface dct_stream_if #(
  parameter int unsigned Width = 16
);
  logic             valid;
  logic             ready;
  logic [Width-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/dct_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module dct_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== design/dct_front.sv =====
// Front end: loads samples into a ping-pong block store and hands full
// blocks to the back end through a two-entry handoff queue.
// Depends on dct_ram.
module dct_front #(
  parameter int unsigned SampleBits = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [SampleBits-1:0] in_data_i,
  input  logic                  inverse_i,
  // back end side
  output logic                  blk_valid_o,
  output logic                  blk_bank_o,
  output logic                  blk_inv_o,
  input  logic                  blk_done_i,
  input  logic                  rd_bank_i,
  input  logic [5:0]            rd_addr_i,
  output logic [SampleBits+7:0] rd_data_o
);
  localparam int unsigned StoreBits = SampleBits + 8;

  logic [5:0]           load_cnt_q, load_cnt_d;
  logic                 wr_bank_q, wr_bank_d;
  logic [1:0]           full_q, full_d;   // per bank: block waiting or in use
  logic [1:0]           inv_q, inv_d;
  logic                 rd_ptr_q, rd_ptr_d;
  logic                 xfer;
  logic [StoreBits-1:0] wdata;

  assign in_ready_o = !full_q[wr_bank_q];
  assign xfer       = in_valid_i && in_ready_o;
  assign wdata      = StoreBits'($signed(in_data_i));

  dct_ram #(.Width(StoreBits), .Depth(128)) u_store (
    .clk_i  (clk_i),
    .we_i   (xfer),
    .waddr_i({wr_bank_q, load_cnt_q}),
    .wdata_i(wdata),
    .raddr_i({rd_bank_i, rd_addr_i}),
    .rdata_o(rd_data_o)
  );

  // load counter, bank fill flags
  always_comb begin
    load_cnt_d = load_cnt_q;
    wr_bank_d  = wr_bank_q;
    full_d     = full_q;
    inv_d      = inv_q;
    rd_ptr_d   = rd_ptr_q;
    if (blk_done_i) begin
      full_d[rd_ptr_q] = 1'b0;
      rd_ptr_d         = !rd_ptr_q;
    end
    if (xfer) begin
      load_cnt_d = load_cnt_q + 6'd1;
      if (load_cnt_q == 6'd63) begin
        full_d[wr_bank_q] = 1'b1;
        inv_d[wr_bank_q]  = inverse_i;
        wr_bank_d         = !wr_bank_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_cnt_q <= '0;
      wr_bank_q  <= 1'b0;
      full_q     <= '0;
      inv_q      <= '0;
      rd_ptr_q   <= 1'b0;
    end else begin
      load_cnt_q <= load_cnt_d;
      wr_bank_q  <= wr_bank_d;
      full_q     <= full_d;
      inv_q      <= inv_d;
      rd_ptr_q   <= rd_ptr_d;
    end
  end

  assign blk_valid_o = full_q[rd_ptr_q];
  assign blk_bank_o  = rd_ptr_q;
  assign blk_inv_o   = inv_q[rd_ptr_q];
endmodule

// ===== design/dct_mul.sv =====
// Shared constant multiplier: value times butterfly constant, rounded to
// nearest with ties away from zero; one registered stage.
// Depends on dct_pkg.
module dct_mul #(
  parameter int unsigned ValBits       = 28,
  parameter int unsigned CoefFracBits  = 14
) (
  input  logic                      clk_i,
  input  logic signed [ValBits-1:0] a_i,
  input  logic [2:0]                k_i,
  output logic signed [ValBits-1:0] p_o
);
  import dct_pkg::*;
  localparam int unsigned CBits = CoefFracBits + 2;
  localparam int unsigned PBits = ValBits + CBits;
  localparam int unsigned Sh    = 30 - CoefFracBits;

  logic [31:0]        kfull;
  logic [CBits-1:0]   c;
  logic               neg;
  logic [ValBits-1:0] mag;
  logic [PBits-1:0]   prod;
  logic [PBits-1:0]   rnd;
  logic [ValBits-1:0] r;

  always_comb begin
    kfull = (k_q30(k_i) + (32'd1 << (Sh - 1))) >> Sh;
    c     = kfull[CBits-1:0];
    neg   = a_i[ValBits-1];
    mag   = neg ? ValBits'(-a_i) : ValBits'(a_i);
    prod  = PBits'(mag) * PBits'(c);
    rnd   = prod + (PBits'(1) << (CoefFracBits - 1));
    r     = rnd[CoefFracBits +: ValBits];
  end

  always_ff @(posedge clk_i) begin
    p_o <= neg ? -$signed(r) : $signed(r);
  end
endmodule

// ===== design/dct_back.sv =====
// Back end: sequencer running the two 1D passes on one block, with a
// working store, one shared multiplier, and the output stage.
// Depends on dct_pkg, dct_mul, dct_ram.
module dct_back #(
  parameter int unsigned SampleBits   = 16,
  parameter int unsigned CoefFracBits = 14
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     blk_valid_i,
  input  logic                     blk_bank_i,
  input  logic                     blk_inv_i,
  output logic                     blk_done_o,
  output logic                     rd_bank_o,
  output logic [5:0]               rd_addr_o,
  input  logic [SampleBits+7:0]    rd_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [SampleBits-1:0]    out_coef_o,
  output logic [5:0]               out_pos_o
);
  import dct_pkg::*;
  localparam int unsigned StoreBits = SampleBits + 8;
  localparam int unsigned VB        = StoreBits + 10;  // headroom for a pass

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_CALC, S_STORE, S_EMIT
  } state_e;

  typedef logic signed [VB-1:0] val_t;

  state_e           state_q;
  logic             pass_q;     // 0: first pass, 1: second pass
  logic             inv_q;
  logic [2:0]       line_q;
  logic [3:0]       idx_q;      // load/store element counter
  logic [5:0]       step_q;     // micro-step in CALC
  logic [6:0]       emit_q;
  val_t             v_q [8];
  val_t             t_q [16];
  logic             rd_pend_q;  // read data of the previous address is valid

  // multiplier
  val_t       mul_a;
  logic [2:0] mul_k;
  val_t       mul_p;

  dct_mul #(.ValBits(VB), .CoefFracBits(CoefFracBits)) u_mul (
    .clk_i(clk_i), .a_i(mul_a), .k_i(mul_k), .p_o(mul_p)
  );

  op_e op;
  logic rows;
  logic [2:0] ld_k;
  logic [5:0] addr_of;
  logic [StoreBits-1:0] wval;
  logic signed [VB-1:0] shv;
  logic signed [VB-1:0] satv;
  val_t hi_s, lo_s;

  // work store and emit addressing
  logic [5:0]           emit_pos;
  logic                 emit_adv;
  logic [5:0]           emit_rd;
  logic                 work_we;
  logic [5:0]           work_raddr;
  logic [StoreBits-1:0] work_rdata;
  logic [StoreBits-1:0] ld_data;
  logic                 last_store;

  always_comb begin
    case ({inv_q, pass_q})
      2'b00:   op = OP_FWD_ROW;
      2'b01:   op = OP_FWD_COL;
      2'b10:   op = OP_INV_COL;
      default: op = OP_INV_ROW;
    endcase
    rows = (op == OP_FWD_ROW) || (op == OP_INV_ROW);
    ld_k = idx_q[2:0];
    addr_of = rows ? {line_q, ld_k} : {ld_k, line_q};
  end

  assign rd_bank_o = blk_bank_i;
  assign rd_addr_o = addr_of;

  // emit reads one address ahead so the read data tracks emit_q
  assign emit_pos   = emit_q[5:0];
  assign emit_adv   = (state_q == S_EMIT) && rd_pend_q && (!out_valid_o || out_ready_i)
                      && (emit_q != 7'd64);
  assign emit_rd    = emit_adv ? emit_pos + 6'd1 : emit_pos;
  assign work_we    = (state_q == S_STORE);
  assign work_raddr = (state_q == S_EMIT) ? emit_rd : addr_of;
  assign ld_data    = pass_q ? work_rdata : rd_data_i;
  assign last_store = (state_q == S_STORE) && (idx_q == 4'd7) && (line_q == 3'd7) && pass_q;

  dct_ram #(.Width(StoreBits), .Depth(64)) u_work (
    .clk_i  (clk_i),
    .we_i   (work_we),
    .waddr_i(addr_of),
    .wdata_i(wval),
    .raddr_i(work_raddr),
    .rdata_o(work_rdata)
  );

  // rounding shifts
  function automatic val_t rsr(input val_t a, input int unsigned s);
    val_t m;
    val_t r;
    begin
      m = a[VB-1] ? -a : a;
      r = (m + (val_t'(1) << (s - 1))) >>> s;
      return a[VB-1] ? -r : r;
    end
  endfunction

  // micro-program: each multiply step issues a product, next step consumes
  // it. t_q slots hold intermediates.
  always_comb begin
    mul_a = '0;
    mul_k = 3'd0;
    if (!inv_q) begin
      case (step_q)
        6'd0: begin mul_a = v_q[0] - v_q[7]; mul_k = 3'd0; end
        6'd1: begin mul_a = v_q[1] - v_q[6]; mul_k = 3'd1; end
        6'd2: begin mul_a = v_q[2] - v_q[5]; mul_k = 3'd2; end
        6'd3: begin mul_a = v_q[3] - v_q[4]; mul_k = 3'd3; end
        6'd5: begin mul_a = t_q[0] - t_q[3]; mul_k = 3'd4; end
        6'd6: begin mul_a = t_q[1] - t_q[2]; mul_k = 3'd5; end
        6'd7: begin mul_a = t_q[4] - t_q[7]; mul_k = 3'd4; end
        6'd8: begin mul_a = t_q[5] - t_q[6]; mul_k = 3'd5; end
        6'd10: begin mul_a = t_q[8] - t_q[9]; mul_k = 3'd6; end   // b1
        6'd11: begin mul_a = t_q[10] - t_q[11]; mul_k = 3'd6; end // b3
        6'd12: begin mul_a = t_q[12] - t_q[13]; mul_k = 3'd6; end // d1
        6'd13: begin mul_a = t_q[14] - t_q[15]; mul_k = 3'd6; end // d3
        default: ;
      endcase
    end else begin
      case (step_q)
        6'd0: begin mul_a = v_q[4]; mul_k = 3'd6; end
        6'd1: begin mul_a = v_q[2] + v_q[6]; mul_k = 3'd6; end
        6'd2: begin mul_a = v_q[3] + v_q[5]; mul_k = 3'd6; end
        6'd3: begin mul_a = v_q[1] + v_q[3] + v_q[5] + v_q[7]; mul_k = 3'd6; end
        6'd5: begin mul_a = t_q[2]; mul_k = 3'd4; end
        6'd6: begin mul_a = t_q[3]; mul_k = 3'd5; end
        6'd7: begin mul_a = t_q[6]; mul_k = 3'd4; end
        6'd8: begin mul_a = t_q[7]; mul_k = 3'd5; end
        6'd10: begin mul_a = t_q[12]; mul_k = 3'd0; end
        6'd11: begin mul_a = t_q[13]; mul_k = 3'd1; end
        6'd12: begin mul_a = t_q[14]; mul_k = 3'd2; end
        6'd13: begin mul_a = t_q[15]; mul_k = 3'd3; end
        default: ;
      endcase
    end
  end

  // saturation of the element being stored
  always_comb begin
    shv = v_q[ld_k];
    if (pass_q) begin
      hi_s = val_t'((VB'(1) << (SampleBits - 1)) - 1);
    end else begin
      hi_s = val_t'((VB'(1) << (StoreBits - 1)) - 1);
    end
    lo_s = -hi_s - val_t'(1);
    satv = (shv > hi_s) ? hi_s : ((shv < lo_s) ? lo_s : shv);
    wval = StoreBits'(satv);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= 1'b0;
      inv_q       <= 1'b0;
      line_q      <= '0;
      idx_q       <= '0;
      step_q      <= '0;
      emit_q      <= '0;
      rd_pend_q   <= 1'b0;
      blk_done_o  <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      blk_done_o <= last_store;
      case (state_q)
        S_IDLE: begin
          if (blk_valid_i) begin
            inv_q   <= blk_inv_i;
            pass_q  <= 1'b0;
            line_q  <= '0;
            idx_q   <= '0;
            rd_pend_q <= 1'b0;
            state_q <= S_LOAD;
          end
        end
        // fetch one line, read data arriving in the cycle after its address;
        // first pass from the block store, second from the work store
        S_LOAD: begin
          if (rd_pend_q) begin
            v_q[idx_q[2:0] - 3'd1] <= val_t'($signed(ld_data));
          end
          if (idx_q == 4'd8) begin
            idx_q   <= '0;
            step_q  <= '0;
            rd_pend_q <= 1'b0;
            state_q <= S_CALC;
          end else begin
            idx_q <= idx_q + 4'd1;
            rd_pend_q <= 1'b1;
          end
        end
        S_CALC: begin
          step_q <= step_q + 6'd1;
          if (!inv_q) begin
            case (step_q)
              6'd0: begin
                t_q[0] <= v_q[0] + v_q[7]; t_q[1] <= v_q[1] + v_q[6];
                t_q[2] <= v_q[2] + v_q[5]; t_q[3] <= v_q[3] + v_q[4];
              end
              6'd1: t_q[4] <= mul_p;
              6'd2: t_q[5] <= mul_p;
              6'd3: t_q[6] <= mul_p;
              6'd4: t_q[7] <= mul_p;
              6'd5: begin
                t_q[8] <= t_q[0] + t_q[3]; t_q[9] <= t_q[1] + t_q[2];
                t_q[12] <= t_q[4] + t_q[7]; t_q[13] <= t_q[5] + t_q[6];
              end
              6'd6: t_q[10] <= mul_p; // a2
              6'd7: t_q[11] <= mul_p; // a3
              6'd8: t_q[14] <= mul_p; // c2
              6'd9: t_q[15] <= mul_p; // c3
              6'd10: begin
                v_q[0] <= t_q[8] + t_q[9];           // b0
                v_q[2] <= t_q[10] + t_q[11];         // b2
                v_q[1] <= t_q[12] + t_q[13];         // d0
                v_q[3] <= t_q[14] + t_q[15];         // d2
              end
              6'd11: v_q[4] <= mul_p; // b1
              6'd12: v_q[6] <= mul_p; // b3
              6'd13: v_q[5] <= mul_p; // d1
              6'd14: v_q[7] <= mul_p; // d3
              6'd15: begin
                // v3=d2 -> o1 = d2 + d3
                v_q[0] <= rsr(v_q[0], 3);
                v_q[1] <= rsr(v_q[1] + v_q[3] + v_q[7], 2);
                v_q[2] <= rsr(v_q[2] + v_q[6], 2);
                v_q[3] <= rsr(v_q[3] + v_q[7] + v_q[5], 2);
                v_q[4] <= rsr(v_q[4], 2);
                v_q[5] <= rsr(v_q[5] + v_q[7], 2);
                v_q[6] <= rsr(v_q[6], 2);
                v_q[7] <= rsr(v_q[7], 2);
                state_q <= S_STORE;
              end
              default: ;
            endcase
          end else begin
            case (step_q)
              6'd1: t_q[0] <= mul_p; // m(v4)
              6'd2: t_q[1] <= mul_p; // m(v2+v6)
              6'd3: t_q[4] <= mul_p; // m(t6)
              6'd4: begin
                t_q[5] <= mul_p;     // m(t5+t7)
                // even: q0,q1,q2,q3 -> t8,t9,t2,t3
                t_q[8] <= v_q[0] + t_q[0];
                t_q[9] <= v_q[0] - t_q[0];
                t_q[2] <= v_q[2] + t_q[1];
                t_q[3] <= v_q[2] - t_q[1];
              end
              6'd5: begin
                // odd: p0=v1, p2=t5=v1+v3
                t_q[10] <= v_q[1] + t_q[4];
                t_q[11] <= v_q[1] - t_q[4];
                t_q[6]  <= v_q[1] + v_q[3] + t_q[5];
                t_q[7]  <= v_q[1] + v_q[3] - t_q[5];
              end
              6'd6: t_q[0] <= mul_p;
              6'd7: t_q[1] <= mul_p;
              6'd8: t_q[4] <= mul_p;
              6'd9: begin
                t_q[5] <= mul_p;
                // e[0..3] into v0..v3 later; odd o[0..3] into t12..t15
              end
              6'd10: ;
              default: ;
            endcase
            // second stage of halves and final products
            if (step_q == 6'd9) begin
              t_q[12] <= t_q[10] + t_q[4];
              t_q[15] <= t_q[10] - t_q[4];
              t_q[13] <= t_q[11] + mul_p;
              t_q[14] <= t_q[11] - mul_p;
              v_q[0]  <= t_q[8] + t_q[0];
              v_q[3]  <= t_q[8] - t_q[0];
              v_q[1]  <= t_q[9] + t_q[1];
              v_q[2]  <= t_q[9] - t_q[1];
            end
            if (step_q == 6'd11) t_q[0] <= mul_p;
            if (step_q == 6'd12) t_q[1] <= mul_p;
            if (step_q == 6'd13) t_q[2] <= mul_p;
            if (step_q == 6'd14) begin
              v_q[0] <= v_q[0] + t_q[0];
              v_q[7] <= v_q[0] - t_q[0];
              v_q[1] <= v_q[1] + t_q[1];
              v_q[6] <= v_q[1] - t_q[1];
              v_q[2] <= v_q[2] + t_q[2];
              v_q[5] <= v_q[2] - t_q[2];
              v_q[3] <= v_q[3] + mul_p;
              v_q[4] <= v_q[3] - mul_p;
              state_q <= S_STORE;
            end
          end
        end
        // write back one line, saturated
        S_STORE: begin
          if (idx_q == 4'd7) begin
            idx_q <= '0;
            line_q <= line_q + 3'd1;
            if (line_q == 3'd7) begin
              if (pass_q) begin
                emit_q  <= '0;
                state_q <= S_EMIT;
              end else begin
                pass_q  <= 1'b1;
                state_q <= S_LOAD;
              end
            end else begin
              state_q <= S_LOAD;
            end
          end else begin
            idx_q <= idx_q + 4'd1;
          end
        end
        // stream results with an output register; the work store read is primed first
        S_EMIT: begin
          if (!rd_pend_q) begin
            rd_pend_q <= 1'b1;
          end else if (!out_valid_o || out_ready_i) begin
            if (emit_q == 7'd64) begin
              out_valid_o <= 1'b0;
              rd_pend_q   <= 1'b0;
              state_q     <= S_IDLE;
            end else begin
              out_valid_o <= 1'b1;
              out_coef_o  <= work_rdata[SampleBits-1:0];
              out_pos_o   <= emit_pos;
              emit_q      <= emit_q + 7'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "dct_idct_8x8_2d_unit_macros.svh"
  `DCT_ASSERT_IMP(a_emit_in_state, clk_i, rst_ni, out_valid_o, state_q == S_EMIT)
  `DCT_ASSERT_NEXT(a_done_pulse, clk_i, rst_ni, blk_done_o, !blk_done_o)
  `DCT_ASSERT_IMP(a_done_leaves, clk_i, rst_ni, blk_done_o, state_q == S_EMIT)
endmodule

// ===== design/dct_idct_8x8_2d_unit.sv =====
// Top level of the 8x8 2D DCT / inverse DCT block.
// Depends on dct_pkg, dct_stream_if, dct_front, dct_back.
//
//  channel   dir  payload
//  in_s      in   sample[15:0]
//  out_s     out  coefficient[15:0], position[5:0], last
//  cfg       in   inverse_mode (we/data)
//
// Loading writes each accepted sample into a two-bank store; the back end
// processes 16 lines per block (each a line read, 16 forward or 15 inverse
// steps, 8 writes, through one shared multiplier), then primes the work store
// read and emits 64 results, one per cycle unless stalled.
// Reset clears control state only; the stores are not cleared.
// Either side may stall; loading of the next block continues while one
// waits, until both banks are full.
module dct_idct_8x8_2d_unit #(
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned COEF_FRAC_BITS = 14
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_data_i,
  dct_stream_if.sink   in_s,
  dct_stream_if.source out_s
);
  import dct_pkg::*;

  logic inv_q;
  logic blk_valid, blk_bank, blk_inv, blk_done, rd_bank;
  logic [5:0] rd_addr;
  logic [SAMPLE_BITS+7:0] rd_data;
  logic [SAMPLE_BITS-1:0] coef;
  logic [PosBits-1:0]     pos;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q <= 1'b0;
    end else if (cfg_we_i) begin
      inv_q <= cfg_data_i;
    end
  end

  dct_front #(.SampleBits(SAMPLE_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(in_s.valid), .in_ready_o(in_s.ready),
    .in_data_i(in_s.data[SAMPLE_BITS-1:0]), .inverse_i(inv_q),
    .blk_valid_o(blk_valid), .blk_bank_o(blk_bank), .blk_inv_o(blk_inv),
    .blk_done_i(blk_done), .rd_bank_i(rd_bank), .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  dct_back #(.SampleBits(SAMPLE_BITS), .CoefFracBits(COEF_FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .blk_valid_i(blk_valid), .blk_bank_i(blk_bank), .blk_inv_i(blk_inv),
    .blk_done_o(blk_done), .rd_bank_o(rd_bank), .rd_addr_o(rd_addr),
    .rd_data_i(rd_data),
    .out_valid_o(out_s.valid), .out_ready_i(out_s.ready),
    .out_coef_o(coef), .out_pos_o(pos)
  );

  // payload: {last, position, coefficient}
  assign out_s.data = {pos == 6'd63, pos, coef};
endmodule

// ===== verif/dct_idct_8x8_2d_unit_tb.sv =====
// Self-checking testbench for the 8x8 2D DCT / inverse DCT block.
// Depends on dct_pkg, dct_stream_if and dct_idct_8x8_2d_unit.
`timescale 1ns / 1ps

// Fixed-point model of the separable Lee transform plus expected-result queue
class dct_block_scoreboard;
  typedef struct {
    logic [15:0] coefficient;
    logic [5:0]  position;
    logic        last;
  } result_t;

  // butterfly constants, 30 fraction bits
  localparam longint KQ30[7] = '{64'sd547388835, 64'sd645689156, 64'sd966342111,
                                 64'sd2751909508, 64'sd581104888, 64'sd1402911301,
                                 64'sd759250125};

  result_t    expected_q[$];
  longint     block_buf[64];
  int         fill_count;
  int         mismatches;
  int         blocks_done;
  int         results_seen;

  function new();
    fill_count   = 0;
    mismatches   = 0;
    blocks_done  = 0;
    results_seen = 0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  // product with constant idx, rounded to nearest, ties away from zero
  function longint mul_const(longint a, int idx);
    longint c, mag, r;
    c   = (KQ30[idx] + (64'sd1 << 15)) >>> 16;
    mag = (a < 0) ? -a : a;
    r   = (mag * c + 64'sd8192) >>> 14;
    return (a < 0) ? -r : r;
  endfunction

  function longint round_shift(longint a, int s);
    longint mag, r;
    mag = (a < 0) ? -a : a;
    r   = (mag + (64'sd1 <<< (s - 1))) >>> s;
    return (a < 0) ? -r : r;
  endfunction

  function longint clamp(longint v, int bits);
    longint hi, lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // forward 8-point line, scaled 1/8 on DC and 2/8 elsewhere
  function void fwd_line(inout longint v[8]);
    longint t0, t1, t2, t3, t4, t5, t6, t7, a0, a1, a2, a3, b0, b1, b2, b3;
    longint c0, c1, c2, c3, d0, d1, d2, d3, o1;
    longint y[8];
    t0 = v[0] + v[7]; t4 = mul_const(v[0] - v[7], 0);
    t1 = v[1] + v[6]; t5 = mul_const(v[1] - v[6], 1);
    t2 = v[2] + v[5]; t6 = mul_const(v[2] - v[5], 2);
    t3 = v[3] + v[4]; t7 = mul_const(v[3] - v[4], 3);
    a0 = t0 + t3; a2 = mul_const(t0 - t3, 4);
    a1 = t1 + t2; a3 = mul_const(t1 - t2, 5);
    b0 = a0 + a1; b1 = mul_const(a0 - a1, 6);
    b2 = a2 + a3; b3 = mul_const(a2 - a3, 6);
    c0 = t4 + t7; c2 = mul_const(t4 - t7, 4);
    c1 = t5 + t6; c3 = mul_const(t5 - t6, 5);
    d0 = c0 + c1; d1 = mul_const(c0 - c1, 6);
    d2 = c2 + c3; d3 = mul_const(c2 - c3, 6);
    o1 = d2 + d3;
    y[0] = b0;      y[1] = d0 + o1;
    y[2] = b2 + b3; y[3] = o1 + d1;
    y[4] = b1;      y[5] = d1 + d3;
    y[6] = b3;      y[7] = d3;
    v[0] = round_shift(y[0], 3);
    for (int k = 1; k < 8; k++) v[k] = round_shift(y[k], 2);
  endfunction

  // even-half butterfly of the inverse
  function void inv_even(longint p0, longint p2, longint p1, longint p3,
                         output longint r[4]);
    longint m, q0, q1, q2, q3;
    m  = mul_const(p1, 6);
    q0 = p0 + m; q1 = p0 - m;
    m  = mul_const(p3, 6);
    q2 = p2 + m; q3 = p2 - m;
    m  = mul_const(q2, 4);
    r[0] = q0 + m; r[3] = q0 - m;
    m  = mul_const(q3, 5);
    r[1] = q1 + m; r[2] = q1 - m;
  endfunction

  function void inv_line(inout longint v[8]);
    longint e[4], o[4];
    longint m, t5, t6, t7;
    t5 = v[1] + v[3]; t6 = v[3] + v[5]; t7 = v[5] + v[7];
    inv_even(v[0], v[2], v[4], v[2] + v[6], e);
    inv_even(v[1], t5, t6, t5 + t7, o);
    for (int k = 0; k < 4; k++) begin
      m = mul_const(o[k], k);
      v[k]     = e[k] + m;
      v[7 - k] = e[k] - m;
    end
  endfunction

  // one 1D pass over all rows or all columns, saturating each output
  function void line_pass(inout longint w[64], input bit rows, input bit inv,
                          input int bits);
    longint v[8];
    for (int i = 0; i < 8; i++) begin
      for (int k = 0; k < 8; k++) v[k] = rows ? w[i*8 + k] : w[k*8 + i];
      if (inv) inv_line(v);
      else fwd_line(v);
      for (int k = 0; k < 8; k++) begin
        if (rows) w[i*8 + k] = clamp(v[k], bits);
        else w[k*8 + i] = clamp(v[k], bits);
      end
    end
  endfunction

  // note one accepted sample; the 64th one produces the block's results
  function void note_sample(logic signed [15:0] s, bit inverse);
    result_t r;
    block_buf[fill_count] = longint'(s);
    if (fill_count < 63) begin
      fill_count++;
      return;
    end
    fill_count = 0;
    line_pass(block_buf, !inverse, inverse, 24);
    line_pass(block_buf, inverse, inverse, 16);
    for (int i = 0; i < 64; i++) begin
      r.coefficient = block_buf[i][15:0];
      r.position    = i[5:0];
      r.last        = (i == 63);
      expected_q.push_back(r);
    end
    blocks_done++;
  endfunction

  task report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  task check_result(logic [15:0] coefficient, logic [5:0] position, logic last);
    result_t e;
    results_seen++;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result pos=%0d coef=%h", position, coefficient));
      return;
    end
    e = expected_q.pop_front();
    if (coefficient !== e.coefficient)
      report($sformatf("pos %0d coefficient %h, want %h", e.position, coefficient,
                       e.coefficient));
    if (position !== e.position)
      report($sformatf("position %0d, want %0d", position, e.position));
    if (last !== e.last)
      report($sformatf("pos %0d last %b, want %b", e.position, last, e.last));
  endtask
endclass

module dct_idct_8x8_2d_unit_tb;
  import dct_pkg::*;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_data_i;
  bit   mode_shadow;
  bit   calm;
  int   stall_left;

  dct_stream_if #(.Width(16)) in_if ();
  dct_stream_if #(.Width(23)) out_if ();

  dct_block_scoreboard sb = new();

  dct_idct_8x8_2d_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_s       (in_if),
    .out_s      (out_if)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  // sample transfers on both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready)
      sb.note_sample(in_if.data, mode_shadow);
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result(out_if.data[15:0], out_if.data[21:16], out_if.data[22]);
  end

  // receiver stalls in random bursts
  always @(negedge clk_i) begin
    if (!rst_ni || calm) begin
      out_if.ready <= 1'b1;
      stall_left   <= 0;
    end else if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, 5);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  task write_mode(bit m);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_data_i  = m;
    mode_shadow = m;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // one sample transfer, with an optional idle burst first
  task send_sample(logic [15:0] s);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_if.valid = 1'b1;
    in_if.data  = s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task release_input();
    @(negedge clk_i);
    in_if.valid = 1'b0;
  endtask

  // random block; style picks the value distribution
  task send_block(int style);
    logic [15:0] s;
    for (int i = 0; i < 64; i++) begin
      case (style)
        0: s = $urandom;
        1: s = 16'($signed($urandom_range(0, 4095)) - 2048);
        2: s = (i % 9 == 0) ? 16'($urandom) : 16'h0000;
        default: s = (i < 32) ? 16'h7fff : 16'h8000;
      endcase
      send_sample(s);
    end
  endtask

  // wait for every result, then let the back end settle
  task drain();
    release_input();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] corner[25];
    corner = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa,
               16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h00ff, 16'hff00, 16'h0f0f,
               16'hf0f0, 16'h0010, 16'hfff0, 16'h4000, 16'hc000, 16'h3333, 16'hcccc,
               16'h7ffe, 16'h8001, 16'h0008, 16'hfff8};
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = 1'b0;
    mode_shadow  = 1'b0;
    calm         = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: field extremes then a random tail, forward mode
    write_mode(1'b0);
    foreach (corner[i]) send_sample(corner[i]);
    for (int i = 25; i < 64; i++) send_sample(16'($urandom));
    drain();

    // inverse on sparse and saturating blocks, back to back
    write_mode(1'b1);
    send_block(2);
    send_block(3);
    drain();

    // forward, mixed ranges
    write_mode(1'b0);
    send_block(1);
    send_block(3);
    drain();

    // last part: no idling on either side
    calm = 1'b1;
    write_mode(1'b1);
    send_block(1);
    drain();

    $display("Covered %0d blocks in both modes, %0d results checked.",
             sb.blocks_done, sb.results_seen);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
